// ===== design/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is held
`define PBJQ_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// clocked check that also holds during reset
`define PBJQ_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== design/pbjq_pkg.sv =====
package pbjq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PAGE_BITS   = 16;

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  // arithmetic width: wide enough for a page count and for the 16-bit budget
  localparam int ARITH_W = (PAGE_BITS > 16) ? PAGE_BITS : 16;

  localparam logic [15:0] BUDGET_RESET = 16'd30;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [ARITH_W-1:0]   arith_t;

  // result of the shared budget unit
  typedef struct packed {
    arith_t rem;          // pages still to print of the head job
    logic   fits;         // rem fits in the budget left
    arith_t budget_left;  // budget minus rem
    page_t  printed_acc;  // printed count advanced by the whole budget
  } alu_res_t;

  function automatic idx_t next_slot(input idx_t i);
    next_slot = (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

endpackage

// ===== design/pbjq_ram.sv =====
module pbjq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/pbjq_alu.sv =====
module pbjq_alu (
  input  pbjq_pkg::page_t    stored,
  input  pbjq_pkg::page_t    printed,
  input  pbjq_pkg::arith_t   budget,
  output pbjq_pkg::alu_res_t res
);
  import pbjq_pkg::*;

  arith_t rem;
  arith_t sum;

  // remaining pages, clamped at zero
  assign rem = (stored > printed) ? arith_t'(stored - printed) : '0;
  assign sum = arith_t'(printed) + budget;

  assign res.rem         = rem;
  assign res.fits        = (rem <= budget);
  assign res.budget_left = budget - rem;
  assign res.printed_acc = sum[PAGE_BITS-1:0];

endmodule

// ===== design/page_budget_job_queue.sv =====
// print job queue with a per-tick page budget
//
// input channel (in_valid / in_ready): one word is a command. in_cmd add
// appends in_job_pages at the tail; tick spends the cfg page budget on jobs
// from the head onward, retiring jobs in order while their remaining pages fit.
// result channel (out_valid / out_ready): exactly one word per input word,
// in order: status, jobs finished, pages spent, jobs left, head pages left.
// config: cfg_we with cfg_data loads the page budget; write only while idle.
//
// an add goes from accept through the head read and the final state to its
// result; a tick first reads and steps each head job it visits (at most
// QUEUE_DEPTH) before those. the cost per job comes from the job store's
// registered read port, read at the head, and one shared compare/subtract
// unit. one word is in work at a time; in_ready is high only while idle.
// a finished result sits in the output register, so the next word is taken
// while the receiver stalls; a following result waits in its final state.
// reset: queue empty, printed count zero, budget 30; store contents unknown.
module page_budget_job_queue (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_job_pages,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [4:0]  out_jobs_finished,
  output logic [15:0] out_pages_done,
  output logic [4:0]  out_queue_count,
  output logic [15:0] out_head_pages_left,

  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import pbjq_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_TICK_RD   = 5'b00010,  // store read of the head in flight
    ST_TICK_STEP = 5'b00100,  // retire or partially print the head job
    ST_HEAD_RD   = 5'b01000,  // read head for the result word
    ST_FIN       = 5'b10000   // result ready to load into output register
  } state_t;

  state_t      state_r, state_nxt;
  idx_t        head_r, head_nxt;
  idx_t        tail_r, tail_nxt;
  cnt_t        count_r, count_nxt;
  page_t       printed_r, printed_nxt;
  arith_t      budget_r, budget_nxt;
  cnt_t        finished_r, finished_nxt;
  logic        status_r, status_nxt;
  logic [15:0] ppt_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_status_r;
  logic [4:0]  out_finished_r;
  logic [15:0] out_done_r;
  logic [4:0]  out_count_r;
  logic [15:0] out_left_r;

  logic        accept;
  logic        ram_we;
  page_t       ram_rd;
  alu_res_t    alu;
  logic        out_free;
  logic        full;
  logic [15:0] spent;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign full     = (count_r == cnt_t'(QUEUE_DEPTH));
  assign out_free = !out_valid_r || out_ready;
  assign ram_we   = accept && (in_cmd == CMD_ADD) && !full;
  // budget never exceeds the register, so the low bits hold the difference
  assign spent    = ppt_r - budget_r[15:0];

  // job store, always reading at the head
  pbjq_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (PAGE_BITS'(in_job_pages)),
    .rd_addr (head_r),
    .rd_data (ram_rd)
  );

  // shared compare / subtract unit
  pbjq_alu u_alu (
    .stored  (ram_rd),
    .printed (printed_r),
    .budget  (budget_r),
    .res     (alu)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    printed_nxt   = printed_r;
    budget_nxt    = budget_r;
    finished_nxt  = finished_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          finished_nxt = '0;
          budget_nxt   = arith_t'(ppt_r);
          status_nxt   = STATUS_OK;
          if (in_cmd == CMD_ADD) begin
            state_nxt = ST_HEAD_RD;
            if (full) begin
              status_nxt = STATUS_FULL;
            end else begin
              tail_nxt  = next_slot(tail_r);
              count_nxt = count_r + cnt_t'(1);
            end
          end else if ((ppt_r == '0) || (count_r == '0)) begin
            state_nxt = ST_HEAD_RD;
          end else begin
            state_nxt = ST_TICK_RD;
          end
        end
      end
      ST_TICK_RD: begin
        state_nxt = ST_TICK_STEP;
      end
      ST_TICK_STEP: begin
        if (alu.fits) begin
          // whole job fits, zero-page jobs included
          budget_nxt   = alu.budget_left;
          head_nxt     = next_slot(head_r);
          count_nxt    = count_r - cnt_t'(1);
          printed_nxt  = '0;
          finished_nxt = finished_r + cnt_t'(1);
          if ((alu.budget_left != '0) && (count_r != cnt_t'(1))) begin
            state_nxt = ST_TICK_RD;
          end else begin
            state_nxt = ST_HEAD_RD;
          end
        end else begin
          printed_nxt = alu.printed_acc;
          budget_nxt  = '0;
          state_nxt   = ST_HEAD_RD;
        end
      end
      ST_HEAD_RD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      printed_r   <= '0;
      ppt_r       <= BUDGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      printed_r   <= printed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ppt_r <= cfg_data;
      end
    end
  end

  // per-word working registers and result payload
  always_ff @(posedge clk) begin
    budget_r   <= budget_nxt;
    finished_r <= finished_nxt;
    status_r   <= status_nxt;
    if ((state_r == ST_FIN) && out_free) begin
      out_status_r   <= status_r;
      out_finished_r <= 5'(finished_r);
      out_done_r     <= spent;
      out_count_r    <= 5'(count_r);
      out_left_r     <= (count_r == '0) ? 16'd0 : 16'(alu.rem);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_jobs_finished   = out_finished_r;
  assign out_pages_done      = out_done_r;
  assign out_queue_count     = out_count_r;
  assign out_head_pages_left = out_left_r;

  `PBJQ_ASSERT(a_count_bound, clk, rst_n, count_r <= cnt_t'(QUEUE_DEPTH), "job count over depth")
  `PBJQ_ASSERT(a_empty_ptrs, clk, rst_n, (count_r == '0) |-> (tail_r == head_r), "empty queue with split pointers")
  `PBJQ_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> !in_ready, "ready right after accept")
  `PBJQ_ASSERT(a_stall_holds, clk, rst_n, (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_done_r)), "stalled result changed")

endmodule

// ===== test/page_budget_job_queue_chk.sv =====
`timescale 1ns / 1ps

module page_budget_job_queue_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_job_pages,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_status,
  input  logic [4:0]  out_jobs_finished,
  input  logic [15:0] out_pages_done,
  input  logic [4:0]  out_queue_count,
  input  logic [15:0] out_head_pages_left,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          awaited,
  output int          rejected_adds,
  output int          jobs_retired
);
  import pbjq_pkg::*;

  typedef struct packed {
    logic        status;
    logic [4:0]  finished;
    logic [15:0] spent;
    logic [4:0]  count;
    logic [15:0] head_left;
  } spool_word_t;

  // private copy of the spooler
  page_t       spool_pages [QUEUE_DEPTH];
  int unsigned head_slot;
  int unsigned tail_slot;
  int unsigned queued;
  page_t       head_printed;
  logic [15:0] budget_reg;

  spool_word_t awaited_words [$];
  int          results_seen;

  initial begin
    mismatches    = 0;
    awaited       = 0;
    rejected_adds = 0;
    jobs_retired  = 0;
    results_seen  = 0;
  end

  function automatic int unsigned head_left();
    if (queued == 0) return 0;
    if (spool_pages[head_slot] > head_printed) return spool_pages[head_slot] - head_printed;
    return 0;
  endfunction

  task automatic spool_apply(input logic cmd, input page_t pages, output spool_word_t w);
    int unsigned left;
    int unsigned rem;
    int unsigned retired;
    w = '0;
    if (cmd == CMD_ADD) begin
      if (queued >= QUEUE_DEPTH) begin
        w.status = STATUS_FULL;
        rejected_adds++;
      end else begin
        spool_pages[tail_slot] = pages;
        tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
        queued++;
      end
    end else begin
      left    = budget_reg;
      retired = 0;
      // retire from the head while budget lasts; zero-page jobs go for free
      while (left > 0 && queued > 0) begin
        rem = head_left();
        if (rem <= left) begin
          left -= rem;
          head_slot = (head_slot + 1) % QUEUE_DEPTH;
          queued--;
          head_printed = '0;
          retired++;
        end else begin
          head_printed = page_t'(head_printed + left);
          left = 0;
        end
      end
      w.status   = STATUS_OK;
      w.finished = 5'(retired);
      w.spent    = 16'(budget_reg - left);
      jobs_retired += retired;
    end
    w.count     = 5'(queued);
    w.head_left = 16'(head_left());
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] result %0d %s: got %0d want %0d", $realtime, results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    spool_word_t want;
    spool_word_t pred;
    if (!rst_n) begin
      head_slot    = 0;
      tail_slot    = 0;
      queued       = 0;
      head_printed = '0;
      budget_reg   = BUDGET_RESET;
      awaited_words.delete();
    end else begin
      // results first: a word accepted at this edge cannot have its result yet
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("result with no word outstanding", 0, 0);
        end else begin
          want = awaited_words.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_jobs_finished !== want.finished)
            report_mismatch("jobs_finished", out_jobs_finished, want.finished);
          if (out_pages_done !== want.spent)
            report_mismatch("pages_done", out_pages_done, want.spent);
          if (out_queue_count !== want.count)
            report_mismatch("queue_count", out_queue_count, want.count);
          if (out_head_pages_left !== want.head_left)
            report_mismatch("head_pages_left", out_head_pages_left, want.head_left);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        spool_apply(in_cmd, in_job_pages, pred);
        awaited_words.push_back(pred);
      end
      if (cfg_we) budget_reg = cfg_data;
    end
    awaited = awaited_words.size();
  end

endmodule

// ===== test/page_budget_job_queue_tb.sv =====
`timescale 1ns / 1ps

module page_budget_job_queue_tb;
  import pbjq_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // cycles a tick can spend on a full queue, plus margin for the drain
  localparam int TAIL_CYCLES = 3 + 2 * QUEUE_DEPTH + 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_ADD;
  logic [15:0] in_job_pages = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [4:0]  out_jobs_finished;
  logic [15:0] out_pages_done;
  logic [4:0]  out_queue_count;
  logic [15:0] out_head_pages_left;

  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  int          mismatches;
  int          awaited;
  int          rejected_adds;
  int          jobs_retired;

  // stimulus bookkeeping
  int          adds_sent = 0;
  int          ticks_sent = 0;
  int          budgets_used = 0;
  int          burst_left = 0;
  int          cycle_count = 0;

  // receiver stall pattern
  int          stall_mode = 0;
  int          stall_run = 0;
  int          stall_phase = 0;

  always #2 clk = ~clk;

  page_budget_job_queue dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_job_pages        (in_job_pages),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_jobs_finished   (out_jobs_finished),
    .out_pages_done      (out_pages_done),
    .out_queue_count     (out_queue_count),
    .out_head_pages_left (out_head_pages_left),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data)
  );

  page_budget_job_queue_chk chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_job_pages        (in_job_pages),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_jobs_finished   (out_jobs_finished),
    .out_pages_done      (out_pages_done),
    .out_queue_count     (out_queue_count),
    .out_head_pages_left (out_head_pages_left),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .mismatches          (mismatches),
    .awaited             (awaited),
    .rejected_adds       (rejected_adds),
    .jobs_retired        (jobs_retired)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, awaited);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: modes held for a random stretch - always ready, coin flip,
  // mostly stalled, or a fixed 3-of-4 pattern
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_phase % 4 != 0);
    endcase
  end

  // present one word at a falling edge and hold it until taken; returns at
  // the falling edge after the accept with valid still high
  task automatic push_word(input logic cmd, input logic [15:0] pages);
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_job_pages <= pages;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    if (cmd == CMD_ADD) adds_sent++;
    else ticks_sent++;
  endtask

  // sender works in bursts of random length; valid drops in the gap between bursts
  task automatic feed_word(input logic cmd, input logic [15:0] pages);
    push_word(cmd, pages);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // drop valid and wait until every result is back, so the block is idle
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic write_budget(input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    budgets_used++;
  endtask

  // page counts scaled to the budget so ticks retire several jobs; big jobs
  // are rare under a tight budget or they would block the head for ages
  function automatic logic [15:0] pick_pages(input int unsigned budget);
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    top  = (budget * 2 + 1 > 65535) ? 65535 : budget * 2 + 1;
    if (budget < 1024) begin
      if (roll < 15) return '0;
      if (roll < 95) return 16'($urandom_range(0, top < 40 ? 40 : top));
      if (roll < 97) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
    end
    if (roll < 15) return '0;
    if (roll < 65) return 16'($urandom_range(0, top));
    if (roll < 80) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // one budget setting with a random mix of adds and ticks; the add share
  // moves around so the queue both fills up and runs dry
  task automatic random_phase(input logic [15:0] budget, input int words);
    int add_pct;
    add_pct = 50;
    drain_results();
    write_budget(budget);
    for (int i = 0; i < words; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: add_pct = 35;
          1: add_pct = 50;
          2: add_pct = 65;
          default: add_pct = 85;
        endcase
      end
      if ($urandom_range(0, 99) < add_pct)
        feed_word(CMD_ADD, pick_pages(budget));
      else
        feed_word(CMD_TICK, 16'($urandom));  // payload is don't-care on a tick
    end
  endtask

  initial begin
    logic [15:0] fill_pages [15];
    fill_pages = '{16'h5555, 16'hAAAA, 16'd0, 16'd1, 16'd29, 16'd30, 16'd31, 16'd0,
                   16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8};

    // synchronous reset, released at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset budget of 30: tick on an empty queue
    feed_word(CMD_TICK, 16'hFFFF);
    // zero-page job, a short job and the largest job
    feed_word(CMD_ADD, 16'd0);
    feed_word(CMD_ADD, 16'd10);
    feed_word(CMD_ADD, 16'hFFFF);
    // zero job goes free, 10 retires, big job gets the remaining 20 pages
    feed_word(CMD_TICK, 16'h0000);
    feed_word(CMD_TICK, 16'h0000);
    // fill to the brim, then two adds against a full queue
    foreach (fill_pages[i]) feed_word(CMD_ADD, fill_pages[i]);
    feed_word(CMD_ADD, 16'h1234);
    feed_word(CMD_ADD, 16'hFFFF);

    // zero budget: a tick on a full queue changes nothing
    drain_results();
    write_budget(16'd0);
    feed_word(CMD_TICK, 16'h0000);
    // full budget: big head job retires, next one partly printed
    drain_results();
    write_budget(16'hFFFF);
    feed_word(CMD_TICK, 16'h0000);
    feed_word(CMD_ADD, 16'd0);
    feed_word(CMD_TICK, 16'h0000);

    // random part over several budget settings, extremes included
    random_phase(16'd1, 85);
    random_phase(16'hFFFF, 85);
    random_phase(16'd30, 85);
    random_phase(16'($urandom_range(2, 200)), 85);
    random_phase(16'($urandom_range(1000, 65534)), 85);
    random_phase(16'd0, 30);
    random_phase(16'd7, 85);
    random_phase(16'($urandom_range(1, 65535)), 85);

    // wait for every result, then give a stray one time to show up
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d adds and %0d ticks across %0d budget settings",
             adds_sent, ticks_sent, budgets_used);
    $display("%0d adds bounced off a full queue, %0d jobs retired by ticks",
             rejected_adds, jobs_retired);
    if (mismatches == 0 && awaited == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, awaited);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/pbjq_pkg.sv
design/pbjq_ram.sv
design/pbjq_alu.sv
design/page_budget_job_queue.sv
test/page_budget_job_queue_chk.sv
test/page_budget_job_queue_tb.sv
